### src/p2rac_pkg.sv
`default_nettype none

package p2rac_pkg;

   localparam int WORD_BITS      = 32;
   localparam int VALUE_BITS     = 32;
   localparam int RADIX_W        = 3;
   localparam int MAX_RADIX_BITS = 5;
   localparam int CHAR_BITS      = 7;
   localparam int DIGIT_TEN      = 10;
   localparam int CHAR_ZERO      = 'h30;
   localparam int CHAR_LETTER_A  = 'h41;

   localparam int USED_BITS  = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   // word is held left aligned so the top digit sits in the upper r bits
   localparam int SHREG_BITS = WORD_BITS + MAX_RADIX_BITS - 1;
   localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
   localparam int SHIFT_BITS = $clog2(SHREG_BITS);

   localparam int DIGITS_R1 = WORD_BITS;
   localparam int DIGITS_R2 = (WORD_BITS + 1) / 2;
   localparam int DIGITS_R3 = (WORD_BITS + 2) / 3;
   localparam int DIGITS_R4 = (WORD_BITS + 3) / 4;
   localparam int DIGITS_R5 = (WORD_BITS + 4) / 5;

   localparam int ALIGN_R1 = SHREG_BITS - DIGITS_R1;
   localparam int ALIGN_R2 = SHREG_BITS - DIGITS_R2 * 2;
   localparam int ALIGN_R3 = SHREG_BITS - DIGITS_R3 * 3;
   localparam int ALIGN_R4 = SHREG_BITS - DIGITS_R4 * 4;
   localparam int ALIGN_R5 = SHREG_BITS - DIGITS_R5 * 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                  bad;
      logic [RADIX_W-1:0]    radix;
      logic [CNT_BITS-1:0]   count;
      logic [SHREG_BITS-1:0] word;
   } job_type;

   function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
      return (r >= RADIX_W'(1)) && (r <= RADIX_W'(MAX_RADIX_BITS));
   endfunction

   function automatic logic [CNT_BITS-1:0] digit_count(input logic [RADIX_W-1:0] r);
      logic [CNT_BITS-1:0] n;
      unique case (r)
         RADIX_W'(1): n = CNT_BITS'(DIGITS_R1);
         RADIX_W'(2): n = CNT_BITS'(DIGITS_R2);
         RADIX_W'(3): n = CNT_BITS'(DIGITS_R3);
         RADIX_W'(4): n = CNT_BITS'(DIGITS_R4);
         RADIX_W'(5): n = CNT_BITS'(DIGITS_R5);
         default:     n = CNT_BITS'(1);
      endcase
      return n;
   endfunction

   function automatic logic [SHIFT_BITS-1:0] align_shift(input logic [RADIX_W-1:0] r);
      logic [SHIFT_BITS-1:0] s;
      unique case (r)
         RADIX_W'(1): s = SHIFT_BITS'(ALIGN_R1);
         RADIX_W'(2): s = SHIFT_BITS'(ALIGN_R2);
         RADIX_W'(3): s = SHIFT_BITS'(ALIGN_R3);
         RADIX_W'(4): s = SHIFT_BITS'(ALIGN_R4);
         RADIX_W'(5): s = SHIFT_BITS'(ALIGN_R5);
         default:     s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_ascii(
      input logic [MAX_RADIX_BITS-1:0] d
   );
      logic [CHAR_BITS-1:0] c;
      if (d < MAX_RADIX_BITS'(DIGIT_TEN)) begin
         c = CHAR_BITS'(CHAR_ZERO) + CHAR_BITS'(d);
      end else begin
         c = CHAR_BITS'(CHAR_LETTER_A) + CHAR_BITS'(d) - CHAR_BITS'(DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/p2rac_chan_if.sv
`default_nettype none

interface p2rac_req_if;
   logic                             valid;
   logic                             ready;
   logic [p2rac_pkg::VALUE_BITS-1:0] value;
   logic [p2rac_pkg::RADIX_W-1:0]    radix_bits;

   modport source (output valid, output value, output radix_bits, input ready);
   modport sink   (input valid, input value, input radix_bits, output ready);
endinterface

interface p2rac_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [p2rac_pkg::CHAR_BITS-1:0] digit_char;
   logic                            last;
   logic                            bad_radix;

   modport source (output valid, output digit_char, output last, output bad_radix,
                   input ready);
   modport sink   (input valid, input digit_char, input last, input bad_radix,
                   output ready);
endinterface

`default_nettype wire

### src/p2rac_front.sv
`default_nettype none

module p2rac_front (
   p2rac_req_if.sink              req_chan,
   input  wire logic              q_full,
   output logic                   q_push,
   output p2rac_pkg::job_type     q_job
);

   logic [p2rac_pkg::SHREG_BITS-1:0] ext_word;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      ext_word = '0;
      ext_word[p2rac_pkg::USED_BITS-1:0] = req_chan.value[p2rac_pkg::USED_BITS-1:0];
      q_job.bad   = !p2rac_pkg::radix_ok(req_chan.radix_bits);
      q_job.radix = req_chan.radix_bits;
      q_job.count = p2rac_pkg::digit_count(req_chan.radix_bits);
      // put the most significant digit (with its zero pad) at the top
      q_job.word  = ext_word << p2rac_pkg::align_shift(req_chan.radix_bits);
   end

endmodule

`default_nettype wire

### src/p2rac_queue.sv
`default_nettype none

module p2rac_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire p2rac_pkg::job_type push_job,
   output logic                    full,
   input  wire logic               pop,
   output logic                    nonempty,
   output p2rac_pkg::job_type      pop_job
);

   p2rac_pkg::job_type                    entry_ff [p2rac_pkg::QUEUE_DEPTH];
   logic [p2rac_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [p2rac_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [p2rac_pkg::QCNT_BITS-1:0]       fill_ff, fill_in;
   logic                                  do_push, do_pop;

   assign full     = (fill_ff == p2rac_pkg::QCNT_BITS'(p2rac_pkg::QUEUE_DEPTH));
   assign nonempty = (fill_ff != '0);
   assign pop_job  = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == p2rac_pkg::QPTR_BITS'(p2rac_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + p2rac_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == p2rac_pkg::QPTR_BITS'(p2rac_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + p2rac_pkg::QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + p2rac_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - p2rac_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### src/p2rac_back.sv
`default_nettype none

module p2rac_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_nonempty,
   input  wire p2rac_pkg::job_type q_job,
   output logic                   q_pop,
   p2rac_rsp_if.source            rsp_chan
);

   logic                                  busy_ff, busy_in;
   logic                                  bad_ff, bad_in;
   logic                                  lead_ff, lead_in;
   logic [p2rac_pkg::SHREG_BITS-1:0]      shreg_ff, shreg_in;
   logic [p2rac_pkg::CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [p2rac_pkg::RADIX_W-1:0]         radix_ff, radix_in;

   logic                                  ovalid_ff, ovalid_in;
   logic [p2rac_pkg::CHAR_BITS-1:0]       ochar_ff, ochar_in;
   logic                                  olast_ff, olast_in;
   logic                                  obad_ff, obad_in;

   logic [p2rac_pkg::MAX_RADIX_BITS-1:0]  top_bits, digit;
   logic                                  final_digit, out_free, emit, skip;

   assign top_bits    = shreg_ff[p2rac_pkg::SHREG_BITS-1 -: p2rac_pkg::MAX_RADIX_BITS];
   assign digit       = top_bits >> (p2rac_pkg::RADIX_W'(p2rac_pkg::MAX_RADIX_BITS) - radix_ff);
   assign final_digit = (cnt_ff == p2rac_pkg::CNT_BITS'(1));
   assign out_free    = !ovalid_ff || rsp_chan.ready;
   // leading zero digits are dropped without using the output slot
   assign skip  = busy_ff && !bad_ff && !lead_ff && (digit == '0) && !final_digit;
   assign emit  = busy_ff && !skip && out_free;
   assign q_pop = !busy_ff && q_nonempty;

   assign rsp_chan.valid      = ovalid_ff;
   assign rsp_chan.digit_char = ochar_ff;
   assign rsp_chan.last       = olast_ff;
   assign rsp_chan.bad_radix  = obad_ff;

   always_comb begin
      busy_in  = busy_ff;
      bad_in   = bad_ff;
      lead_in  = lead_ff;
      shreg_in = shreg_ff;
      cnt_in   = cnt_ff;
      radix_in = radix_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         bad_in   = q_job.bad;
         lead_in  = 1'b0;
         shreg_in = q_job.word;
         cnt_in   = q_job.count;
         radix_in = q_job.radix;
      end else if (skip || emit) begin
         if (emit && (bad_ff || final_digit)) begin
            busy_in = 1'b0;
         end else begin
            shreg_in = shreg_ff << radix_ff;
            cnt_in   = cnt_ff - p2rac_pkg::CNT_BITS'(1);
            lead_in  = lead_ff || emit;
         end
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      obad_in   = obad_ff;
      if (emit) begin
         ovalid_in = 1'b1;
         ochar_in  = bad_ff ? '0 : p2rac_pkg::digit_ascii(digit);
         olast_in  = bad_ff || final_digit;
         obad_in   = bad_ff;
      end else if (rsp_chan.ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff   <= bad_in;
      lead_ff  <= lead_in;
      shreg_ff <= shreg_in;
      cnt_ff   <= cnt_in;
      radix_ff <= radix_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
      obad_ff  <= obad_in;
   end

endmodule

`default_nettype wire

### src/pow2_radix_ascii_converter_core.sv
// Channel   Dir  Payload                           Handshake
// req_chan  in   value[31:0], radix_bits[2:0]      valid/ready
// rsp_chan  out  digit_char[6:0], last, bad_radix  valid/ready
//
// A queued item is taken into the digit unit, which then drops each leading
// zero digit and emits each remaining character in turn; a rejected radix
// gives a single error item.
// The front accepts into a 2-entry queue while the digit unit works.
// Reset is synchronous and clears the queue, the unit and the output valid.
// A stalled output holds the digit unit once it has a character to emit; the queue keeps taking items until full.
`default_nettype none

module pow2_radix_ascii_converter_core (
   input  wire logic   clock,
   input  wire logic   reset,
   p2rac_req_if.sink   req_chan,
   p2rac_rsp_if.source rsp_chan
);

   p2rac_pkg::job_type push_job, pop_job;
   logic               q_full, q_push, q_pop, q_nonempty;

   p2rac_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   p2rac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .pop_job  (pop_job)
   );

   p2rac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### src/p2rac_checker.sv
`default_nettype none

module p2rac_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [p2rac_pkg::CHAR_BITS-1:0] rsp_digit_char,
   input wire logic                            rsp_last,
   input wire logic                            rsp_bad_radix
);

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_radix) |-> (rsp_last && (rsp_digit_char == '0)))
      else $error("rejected radix result must be a lone zero item");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_radix) |->
         ((rsp_digit_char >= 7'h30 && rsp_digit_char <= 7'h39) ||
          (rsp_digit_char >= 7'h41 && rsp_digit_char <= 7'h56)))
      else $error("digit character outside 0-9, A-V");

   a_no_bad_midrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> !(rsp_valid && rsp_bad_radix))
      else $error("error result inside a digit run");

   a_no_zero_lead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=>
         !(rsp_valid && !rsp_last && (rsp_digit_char == 7'h30)))
      else $error("leading zero digit emitted");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last) &&
          $stable(rsp_bad_radix)))
      else $error("stalled result changed");

endmodule

bind pow2_radix_ascii_converter_core p2rac_checker u_p2rac_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_digit_char (rsp_chan.digit_char),
   .rsp_last       (rsp_chan.last),
   .rsp_bad_radix  (rsp_chan.bad_radix)
);

`default_nettype wire
